// ===== design/cpid_pkg.sv =====
// Shared types and constants for the clamped PID controller.
// Holds the request/result payload structs, the register map and the clamp helper.
// No dependencies.
package cpid_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int GAIN_WIDTH     = 32;
    localparam int LIMIT_WIDTH    = 31;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int ACC_WIDTH      = 64;
    localparam int PROD_SAT_SHIFT = 60;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_KP             = 3'd0,
        CFG_KI_HALF_PERIOD = 3'd1,
        CFG_KD_PER_PERIOD  = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] error_value;
        logic                         clear_history;
    } pid_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive_value;
        logic signed [DATA_WIDTH-1:0] integral_value;
    } pid_out_t;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0]  kp;
        logic [GAIN_WIDTH-1:0]  ki_half_period;
        logic [GAIN_WIDTH-1:0]  kd_per_period;
        logic [LIMIT_WIDTH-1:0] integral_limit;
        logic [LIMIT_WIDTH-1:0] output_limit;
    } pid_cfg_t;

    localparam logic [GAIN_WIDTH-1:0]  KP_RESET             = 32'd10066330;
    localparam logic [GAIN_WIDTH-1:0]  KI_HALF_PERIOD_RESET = 32'd117441;
    localparam logic [GAIN_WIDTH-1:0]  KD_PER_PERIOD_RESET  = 32'd125829120;
    localparam logic [LIMIT_WIDTH-1:0] INTEGRAL_LIMIT_RESET = 31'd26214400;
    localparam logic [LIMIT_WIDTH-1:0] OUTPUT_LIMIT_RESET   = 31'd26214400;

    localparam logic signed [ACC_WIDTH-1:0] DATA_MAX =
        (ACC_WIDTH'(1) <<< (DATA_WIDTH - 1)) - ACC_WIDTH'(1);

    function automatic logic signed [DATA_WIDTH-1:0] clamp_sym(
        input logic signed [ACC_WIDTH-1:0] v,
        input logic [LIMIT_WIDTH-1:0]      limit
    );
        logic signed [ACC_WIDTH-1:0] lim;
        logic signed [ACC_WIDTH-1:0] res;
        lim = $signed(ACC_WIDTH'(limit));
        if (lim > DATA_MAX) begin
            lim = DATA_MAX;
        end
        if (v > lim) begin
            res = lim;
        end else if (v < -lim) begin
            res = -lim;
        end else begin
            res = v;
        end
        return res[DATA_WIDTH-1:0];
    endfunction

endpackage

// ===== design/clamped_pid_controller.sv =====
// Clamped PID controller top level: request register, step logic, result register.
// Depends on cpid_pkg, cpid_cfg_regs, cpid_core.
//
// Usage:
//   s_valid/s_ready/s_data carry one error sample per request, with a flag
//   that zeroes the stored error and integral after that step.
//   m_valid/m_ready/m_data return the clamped drive value and the clamped
//   integral of that step, one result per request, in request order.
//   cfg_wr_en/cfg_index/cfg_wdata write the gains and limits; write only
//   while no request is in flight.
// Path: an accepted request is loaded into the request register; its result
//   is loaded into the result register when the output is free, and m_valid
//   rises with it.
// Throughput: one request per cycle while m_ready is high; the step (three
//   multiplies, two clamped sums, the history update) sits between both registers.
// Reset: clears both valid flags and the stored history and reloads the
//   default gains and limits; s_ready is high right after reset.
// Stall: while m_ready is low the result holds, the request register fills,
//   and then s_ready drops until the result is taken.
module clamped_pid_controller #(
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cpid_pkg::pid_in_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cpid_pkg::pid_out_t                  m_data,
    input  logic                                cfg_wr_en,
    input  logic [cpid_pkg::CFG_ADDR_WIDTH-1:0] cfg_index,
    input  logic [cpid_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);
    import cpid_pkg::*;

    pid_cfg_t cfg;
    pid_out_t step_result;

    logic     in_valid_reg;
    logic     in_valid_next;
    pid_in_t  in_data_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    pid_out_t out_data_reg;
    logic     advance;
    logic     s_accept;

    cpid_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cpid_core #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .req     (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== design/cpid_cfg_regs.sv =====
// Gain and limit register bank of the clamped PID controller.
// Decodes the plain write port into the config struct; depends on cpid_pkg.
module cpid_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cpid_pkg::CFG_ADDR_WIDTH-1:0] cfg_index,
    input  logic [cpid_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
    output cpid_pkg::pid_cfg_t                  cfg
);
    import cpid_pkg::*;

    pid_cfg_t cfg_reg;
    pid_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KP:             cfg_next.kp             = cfg_wdata[GAIN_WIDTH-1:0];
                CFG_KI_HALF_PERIOD: cfg_next.ki_half_period = cfg_wdata[GAIN_WIDTH-1:0];
                CFG_KD_PER_PERIOD:  cfg_next.kd_per_period  = cfg_wdata[GAIN_WIDTH-1:0];
                CFG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_wdata[LIMIT_WIDTH-1:0];
                CFG_OUTPUT_LIMIT:   cfg_next.output_limit   = cfg_wdata[LIMIT_WIDTH-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp             <= KP_RESET;
            cfg_reg.ki_half_period <= KI_HALF_PERIOD_RESET;
            cfg_reg.kd_per_period  <= KD_PER_PERIOD_RESET;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RESET;
            cfg_reg.output_limit   <= OUTPUT_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/cpid_scale_mul.sv =====
// Signed value times unsigned gain, floor-shifted by the gain fraction bits
// and saturated symmetrically; depends on cpid_pkg.
module cpid_scale_mul #(
    parameter int IN_WIDTH       = 33,
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic signed [IN_WIDTH-1:0]            x,
    input  logic [cpid_pkg::GAIN_WIDTH-1:0]       gain,
    output logic signed [cpid_pkg::ACC_WIDTH-1:0] y
);
    import cpid_pkg::*;

    localparam int PROD_W = IN_WIDTH + GAIN_WIDTH + 1;
    localparam int EXT_W  = (PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH;
    localparam logic signed [EXT_W-1:0] SAT_POS = EXT_W'(1) <<< PROD_SAT_SHIFT;
    localparam logic signed [EXT_W-1:0] SAT_NEG = -SAT_POS;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    logic signed [EXT_W-1:0]  ext;
    logic signed [EXT_W-1:0]  sat;

    assign prod    = PROD_W'(x) * PROD_W'($signed({1'b0, gain}));
    assign shifted = prod >>> GAIN_FRAC_BITS;
    assign ext     = EXT_W'(shifted);

    always_comb begin
        if (ext > SAT_POS) begin
            sat = SAT_POS;
        end else if (ext < SAT_NEG) begin
            sat = SAT_NEG;
        end else begin
            sat = ext;
        end
    end

    assign y = $signed(sat[ACC_WIDTH-1:0]);

endmodule

// ===== design/cpid_core.sv =====
// PID step logic with stored last error and integral term.
// Uses three cpid_scale_mul instances and the clamp from cpid_pkg.
module cpid_core #(
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  cpid_pkg::pid_in_t    req,
    input  cpid_pkg::pid_cfg_t   cfg,
    output cpid_pkg::pid_out_t   result
);
    import cpid_pkg::*;

    logic signed [DATA_WIDTH-1:0] last_error_reg;
    logic signed [DATA_WIDTH-1:0] last_error_next;
    logic signed [DATA_WIDTH-1:0] integral_reg;
    logic signed [DATA_WIDTH-1:0] integral_next;

    logic signed [DATA_WIDTH:0]   err_sum;
    logic signed [DATA_WIDTH:0]   err_diff;
    logic signed [ACC_WIDTH-1:0]  p_term;
    logic signed [ACC_WIDTH-1:0]  i_incr;
    logic signed [ACC_WIDTH-1:0]  d_term;
    logic signed [ACC_WIDTH-1:0]  i_new;
    logic signed [ACC_WIDTH-1:0]  drive_sum;
    logic signed [DATA_WIDTH-1:0] i_term;
    logic signed [DATA_WIDTH-1:0] drive;

    assign err_sum  = (DATA_WIDTH+1)'(req.error_value) + (DATA_WIDTH+1)'(last_error_reg);
    assign err_diff = (DATA_WIDTH+1)'(req.error_value) - (DATA_WIDTH+1)'(last_error_reg);

    cpid_scale_mul #(
        .IN_WIDTH       (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_p_mul (
        .x    (req.error_value),
        .gain (cfg.kp),
        .y    (p_term)
    );

    cpid_scale_mul #(
        .IN_WIDTH       (DATA_WIDTH + 1),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_i_mul (
        .x    (err_sum),
        .gain (cfg.ki_half_period),
        .y    (i_incr)
    );

    cpid_scale_mul #(
        .IN_WIDTH       (DATA_WIDTH + 1),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_d_mul (
        .x    (err_diff),
        .gain (cfg.kd_per_period),
        .y    (d_term)
    );

    assign i_new     = ACC_WIDTH'(integral_reg) + i_incr;
    assign i_term    = clamp_sym(i_new, cfg.integral_limit);
    assign drive_sum = p_term + ACC_WIDTH'(i_term) + d_term;
    assign drive     = clamp_sym(drive_sum, cfg.output_limit);

    assign result.drive_value    = drive;
    assign result.integral_value = i_term;

    always_comb begin
        last_error_next = last_error_reg;
        integral_next   = integral_reg;
        if (step) begin
            if (req.clear_history) begin
                last_error_next = '0;
                integral_next   = '0;
            end else begin
                last_error_next = req.error_value;
                integral_next   = i_term;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
            integral_reg   <= '0;
        end else begin
            last_error_reg <= last_error_next;
            integral_reg   <= integral_next;
        end
    end

endmodule

// ===== design/cpid_checker.sv =====
// Port-level checks for the clamped PID controller, bound to its top level.
// Depends on cpid_pkg and clamped_pid_controller.
module cpid_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input cpid_pkg::pid_out_t                  m_data
);
    import cpid_pkg::*;

    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("request refused while the output side can move");

    a_clamp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.drive_value != DATA_MIN) && (m_data.integral_value != DATA_MIN))
        else $error("result outside the symmetric clamp range");

endmodule

bind clamped_pid_controller cpid_checker u_cpid_checker (.*);
